/* hw/rtl/gsa_pkg.sv */
// gsa_pkg: request and response types, op codes and field widths for the
// generational slot allocator. No dependencies.
package gsa_pkg;

	localparam int SLOTS_DEF = 1024;
	localparam int SLOT_W    = 10;
	localparam int GEN_W     = 32;
	localparam int LIVE_W    = 11;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_ALIVE   = 2'd2,
		OP_FRAME   = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [GEN_W-1:0]  generation;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [SLOT_W-1:0] handle_slot;
		logic [GEN_W-1:0]  handle_generation;
		logic [LIVE_W-1:0] live_total;
	} rsp_t;

endpackage

/* hw/rtl/gsa_ram.sv */
// gsa_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
module gsa_ram #(
	parameter int W = 32,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/generational_slot_allocator_unit.sv */
// generational_slot_allocator_unit: top level; sequencer around the generation
// RAM and the slot-list RAM (free stack and parked list). Uses gsa_pkg, gsa_ram.
// Allocate at the high-water mark finishes in the cycle it is accepted; allocate from
// the free stack does a stack read, then a generation read-modify-write; release and
// alive read the generation, or finish on acceptance when the slot is beyond the mark;
// begin frame walks the parked list. One request in flight; the next is taken the
// cycle after the response is loaded, and a response held by rsp_stall stalls input.
// Reset clears counters and handshake state only; RAM contents stay undefined and
// no clearing pass runs, since only entries below the counters are ever read.
module generational_slot_allocator_unit #(
	parameter int SLOTS = gsa_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  gsa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output gsa_pkg::rsp_t rsp
);

	import gsa_pkg::*;

	localparam int SW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);
	localparam int STK_D = 2 * (1 << SW);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_POP  = 5'b00010,
		ST_GEN  = 5'b00100,
		ST_COPY = 5'b01000,
		ST_RESP = 5'b10000
	} state_t;

	state_t state_q, state_d;
	req_t   req_q;
	rsp_t   rsp_q, res_q, res;
	logic   rsp_v_q;

	logic [CW-1:0] fd_q, fd_d, pd_q, pd_d, hm_q, hm_d, live_q, live_d;
	logic [CW-1:0] cp_idx_q, cp_idx_d, fd_dec;
	logic [SW-1:0] gaddr_q, gaddr_d;
	logic          cp_v_s1, cp_v_d;

	// generation RAM ports
	logic             gen_we, gen_re;
	logic [SW-1:0]    gen_waddr, gen_raddr;
	logic [GEN_W-1:0] gen_wdata, gen_rdata, gen_inc;

	// slot-list RAM ports: upper half parked list, lower half free stack
	logic          stk_we, stk_re;
	logic [SW:0]   stk_waddr, stk_raddr;
	logic [SW-1:0] stk_wdata, stk_rdata;

	logic                   req_fire, out_free, fin, load_new, load_res;
	logic                   ok_c, s_known, alive;
	logic [SW-1:0]          hs_idx;
	logic [GEN_W-1:0]       hg_c;
	logic [CW+SLOT_W-1:0]   s_wide, hm_wide;
	logic [SW+SLOT_W-1:0]   hs_wide;
	logic [CW+LIVE_W-1:0]   live_wide;

	gsa_ram #(.W(GEN_W), .D(SLOTS)) u_gen_ram (
		.clk   (clk),
		.we    (gen_we),
		.waddr (gen_waddr),
		.wdata (gen_wdata),
		.re    (gen_re),
		.raddr (gen_raddr),
		.rdata (gen_rdata)
	);

	gsa_ram #(.W(SW), .D(STK_D)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// handshake
	assign req_stall = (state_q != ST_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign out_free  = !rsp_v_q || !rsp_stall;
	assign rsp_valid = rsp_v_q;
	assign rsp       = rsp_q;

	// slot range check against the high-water mark
	assign s_wide  = {{CW{1'b0}}, req.slot};
	assign hm_wide = {{SLOT_W{1'b0}}, hm_q};
	assign s_known = s_wide < hm_wide;
	assign fd_dec  = fd_q - 1'b1;
	assign gen_inc = gen_rdata + 1'b1;
	assign alive   = (gen_rdata == req_q.generation) && req_q.generation[0];

	// response assembly
	assign hs_wide   = {{SLOT_W{1'b0}}, hs_idx};
	assign live_wide = {{LIVE_W{1'b0}}, live_d};
	assign res       = {ok_c, hs_wide[SLOT_W-1:0], hg_c, live_wide[LIVE_W-1:0]};

	// sequencer; every RAM write lands before the next
	// request is accepted, so no read can see a stale entry
	always_comb begin
		state_d   = state_q;
		fd_d      = fd_q;
		pd_d      = pd_q;
		hm_d      = hm_q;
		live_d    = live_q;
		gaddr_d   = gaddr_q;
		cp_idx_d  = cp_idx_q;
		cp_v_d    = 1'b0;
		fin       = 1'b0;
		ok_c      = 1'b0;
		hs_idx    = '0;
		hg_c      = '0;
		gen_we    = 1'b0;
		gen_waddr = gaddr_q;
		gen_wdata = gen_inc;
		gen_re    = 1'b0;
		gen_raddr = gaddr_q;
		stk_we    = 1'b0;
		stk_waddr = {1'b1, pd_q[SW-1:0]};
		stk_wdata = gaddr_q;
		stk_re    = 1'b0;
		stk_raddr = {1'b0, fd_dec[SW-1:0]};

		unique case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					case (req.op) inside
						OP_ALLOC: begin
							if (fd_q != '0) begin
								// pop the free stack
								stk_re  = 1'b1;
								fd_d    = fd_dec;
								state_d = ST_POP;
							end else if (hm_q < CW'(SLOTS)) begin
								// fresh slot at the mark, generation 0 -> 1
								gen_we    = 1'b1;
								gen_waddr = hm_q[SW-1:0];
								gen_wdata = GEN_W'(1);
								hm_d      = hm_q + 1'b1;
								live_d    = live_q + 1'b1;
								fin       = 1'b1;
								ok_c      = 1'b1;
								hs_idx    = hm_q[SW-1:0];
								hg_c      = GEN_W'(1);
							end else begin
								fin = 1'b1;
							end
						end
						OP_RELEASE, OP_ALIVE: begin
							if (s_known) begin
								gen_re    = 1'b1;
								gen_raddr = s_wide[SW-1:0];
								gaddr_d   = s_wide[SW-1:0];
								state_d   = ST_GEN;
							end else begin
								fin = 1'b1;
							end
						end
						default: begin
							cp_idx_d = '0;
							state_d  = ST_COPY;
						end
					endcase
				end
			end
			ST_POP: begin
				// popped slot arrives, fetch its generation
				gen_re    = 1'b1;
				gen_raddr = stk_rdata;
				gaddr_d   = stk_rdata;
				state_d   = ST_GEN;
			end
			ST_GEN: begin
				fin = 1'b1;
				case (req_q.op)
					OP_ALLOC: begin
						gen_we = 1'b1;
						live_d = live_q + 1'b1;
						ok_c   = 1'b1;
						hs_idx = gaddr_q;
						hg_c   = gen_inc;
					end
					OP_RELEASE: begin
						if (alive) begin
							gen_we = 1'b1;
							ok_c   = 1'b1;
							if (pd_q < CW'(SLOTS)) begin
								stk_we = 1'b1;
								pd_d   = pd_q + 1'b1;
							end
							if (live_q != '0) begin
								live_d = live_q - 1'b1;
							end
						end
					end
					default: begin
						ok_c = alive;
					end
				endcase
			end
			ST_COPY: begin
				// read parked entries in order, append them to the free stack
				if (cp_idx_q != pd_q) begin
					stk_re    = 1'b1;
					stk_raddr = {1'b1, cp_idx_q[SW-1:0]};
					cp_idx_d  = cp_idx_q + 1'b1;
					cp_v_d    = 1'b1;
				end
				if (cp_v_s1) begin
					if (fd_q < CW'(SLOTS)) begin
						stk_we    = 1'b1;
						stk_waddr = {1'b0, fd_q[SW-1:0]};
						stk_wdata = stk_rdata;
						fd_d      = fd_q + 1'b1;
					end
				end
				if ((cp_idx_q == pd_q) && !cp_v_s1) begin
					pd_d = '0;
					fin  = 1'b1;
					ok_c = 1'b1;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (fin) begin
			state_d = out_free ? ST_IDLE : ST_RESP;
		end
	end

	assign load_new = fin && out_free;
	assign load_res = (state_q == ST_RESP) && out_free;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fd_q     <= '0;
			pd_q     <= '0;
			hm_q     <= '0;
			live_q   <= '0;
			cp_idx_q <= '0;
			cp_v_s1  <= 1'b0;
			rsp_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			fd_q     <= fd_d;
			pd_q     <= pd_d;
			hm_q     <= hm_d;
			live_q   <= live_d;
			cp_idx_q <= cp_idx_d;
			cp_v_s1  <= cp_v_d;
			if (load_new || load_res) begin
				rsp_v_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		gaddr_q <= gaddr_d;
		if (req_fire) begin
			req_q <= req;
		end
		if (fin && !out_free) begin
			res_q <= res;
		end
		if (load_new) begin
			rsp_q <= res;
		end else if (load_res) begin
			rsp_q <= res_q;
		end
	end

	// assertions
	logic [CW+1:0] acct_sum, acct_mark;
	assign acct_sum  = {2'b00, fd_q} + {2'b00, pd_q} + {2'b00, live_q};
	assign acct_mark = {2'b00, hm_q};

	// every slot below the mark is free, parked or live between requests
	a_accounting: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (acct_sum == acct_mark))
		else $error("slot accounting mismatch");

	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		hm_q <= CW'(SLOTS))
		else $error("high-water mark beyond slot count");

	// a held result only waits while the response register is occupied
	a_resp_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) |-> rsp_v_q)
		else $error("result parked with response register empty");

	a_copy_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		cp_v_s1 |-> (state_q == ST_COPY) && $past(state_q == ST_COPY))
		else $error("copy data outside begin frame");

	a_copy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |-> (cp_idx_q <= pd_q))
		else $error("copy index past parked count");

endmodule
